FILE: rtl/core/mwf_pkg.sv
// Package for the marker watershed flood unit.
// Holds the state, phase and code types, label marks and the colour distance function.
// Used by the channel interfaces and by the top level.
package mwf_pkg;

   localparam int LEVEL_BITS  = 8;
   localparam int LEVELS      = 256;
   localparam int LSTORE_BITS = 17;
   localparam int COLOUR_BITS = 24;
   localparam int DIM_BITS    = 9;
   localparam int CSR_IDX_BITS = 8;
   localparam int MIN_DIM     = 3;

   typedef logic signed [LSTORE_BITS-1:0] label_type;
   typedef logic [COLOUR_BITS-1:0]        colour_type;
   typedef logic [LEVEL_BITS-1:0]         level_type;
   typedef logic [DIM_BITS-1:0]           dim_type;

   localparam label_type MARK_QUEUED = -17'sd2;
   localparam label_type MARK_WSHED  = -17'sd1;
   localparam label_type MARK_NONE   = 17'sd0;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   localparam logic [CSR_IDX_BITS-1:0] REG_IMAGE_WIDTH  = 8'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_IMAGE_HEIGHT = 8'd1;

   typedef enum logic {
      PH_LOADING,
      PH_READING
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_NEXT,
      ST_FETCH,
      ST_WAIT,
      ST_INIT_EVAL,
      ST_PUSH_A,
      ST_PUSH_B,
      ST_SCAN,
      ST_POP_A,
      ST_POP_B,
      ST_POP_C,
      ST_FL_EVAL,
      ST_FL_NB
   } state_type;

   function automatic level_type chan_diff(input logic [7:0] a, input logic [7:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   function automatic level_type colour_dist(input colour_type a, input colour_type b);
      level_type d;
      level_type t;
      d = chan_diff(a[7:0], b[7:0]);
      t = chan_diff(a[15:8], b[15:8]);
      if (t > d) d = t;
      t = chan_diff(a[23:16], b[23:16]);
      if (t > d) d = t;
      return d;
   endfunction

endpackage

FILE: rtl/core/mwf_channels_if.sv
// Channel interfaces of the marker watershed flood unit: request, response and register write.
// Uses mwf_pkg for the register index width.
interface mwf_req_if;
   logic       valid;
   logic       ready;
   logic       opcode;
   logic [7:0] pixel_blue;
   logic [7:0] pixel_green;
   logic [7:0] pixel_red;
   logic [14:0] marker_label;
   logic       final_pixel;
   modport source (output valid, opcode, pixel_blue, pixel_green, pixel_red, marker_label,
                   final_pixel, input ready);
   modport sink (input valid, opcode, pixel_blue, pixel_green, pixel_red, marker_label,
                 final_pixel, output ready);
endinterface

interface mwf_rsp_if #(parameter int LABEL_BITS = 16);
   logic                         valid;
   logic                         ready;
   logic signed [LABEL_BITS-1:0] region_label;
   logic                         final_label;
   modport source (output valid, region_label, final_label, input ready);
   modport sink (input valid, region_label, final_label, output ready);
endinterface

interface mwf_csr_if;
   logic                                valid;
   logic                                ready;
   logic [mwf_pkg::CSR_IDX_BITS-1:0]    index;
   logic [mwf_pkg::DIM_BITS-1:0]        data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/core/marker_watershed_flood_unit.sv
// Marker-controlled watershed unit: pixel, label, link and level queue memories and the sequencer.
// Depends on mwf_pkg and the channel interfaces in mwf_channels_if.sv.
//
// Loads take one request per cycle while idle and no response is held back; each stores one
// pixel and its marker. The load that carries final_pixel, or fills the last position, starts
// flooding, during which no request is taken. The flood first sweeps the image once: each border
// pixel is marked as watershed, each interior pixel takes five single-port reads, evaluation and
// advance, and each queued pixel is pushed. It then pops the level queues, stepping upward over
// empty levels; each popped pixel is read with its neighbors and labelled, and unless it is a
// watershed its unlabelled neighbors are queued. Label and colour memories have one read port.
// Readout then returns one label per cycle while responses are accepted. Reset clears no memory.
module marker_watershed_flood_unit #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256,
   parameter int LABEL_BITS = 16
) (
   input  logic     clock,
   input  logic     reset,
   mwf_req_if.sink  req_chan,
   mwf_rsp_if.source rsp_chan,
   mwf_csr_if.sink  csr_chan
);

   localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(CELLS);
   localparam int CMPW  = (AW + 1 > 2 * mwf_pkg::DIM_BITS) ? AW + 1 : 2 * mwf_pkg::DIM_BITS;
   localparam int RST_W = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
   localparam int RST_H = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;

   mwf_pkg::colour_type colour_mem [CELLS];
   mwf_pkg::label_type  label_mem  [CELLS];
   logic [AW-1:0]       link_mem   [CELLS];
   logic [AW-1:0]       head_mem   [mwf_pkg::LEVELS];
   logic [AW-1:0]       tail_mem   [mwf_pkg::LEVELS];

   mwf_pkg::state_type  state_ff, state_in;
   mwf_pkg::phase_type  phase_ff;
   mwf_pkg::dim_type    width_ff, height_ff;
   logic [AW-1:0]       load_pos_ff, read_pos_ff;
   logic [mwf_pkg::LEVELS-1:0] nonempty_ff;
   mwf_pkg::level_type  cur_level_ff;
   logic                init_mode_ff;
   logic [AW-1:0]       cur_p_ff;
   mwf_pkg::dim_type    row_ff, col_ff;
   logic [2:0]          fe_k_ff;
   logic                cap_vld_ff;
   logic [2:0]          cap_k_ff;
   logic [1:0]          nb_k_ff;
   mwf_pkg::colour_type self_col_ff;
   mwf_pkg::label_type  self_lab_ff;
   mwf_pkg::label_type  nb_lab_ff [4];
   mwf_pkg::level_type  dist_ff [4];
   logic [AW-1:0]       tgt_ff;
   mwf_pkg::level_type  lev_ff;
   logic                rsp_valid_ff;
   logic                rsp_final_ff;

   mwf_pkg::colour_type colour_rd_ff;
   mwf_pkg::label_type  label_rd_ff;
   logic [AW-1:0]       link_rd_ff, head_rd_ff, tail_rd_ff;

   logic                lab_re, lab_we, col_re, col_we, link_re, link_we;
   logic                head_re, head_we, tail_re, tail_we;
   logic [AW-1:0]       lab_raddr, lab_waddr, col_raddr, col_waddr, link_raddr, link_waddr;
   logic [AW-1:0]       link_wdata, head_wdata, tail_wdata;
   mwf_pkg::level_type  head_raddr, head_waddr, tail_raddr, tail_waddr;
   mwf_pkg::label_type  lab_wdata;

   logic [2*mwf_pkg::DIM_BITS-1:0] n_cells;
   logic [CMPW-1:0]     n_last;
   logic                req_acc, load_acc, read_acc, flood_go, csr_acc;
   logic [AW-1:0]       ld_base, ld_p, rd_p;
   logic                ld_last, rd_last;
   logic [AW-1:0]       nbr [4];
   logic [AW-1:0]       fe_addr;
   logic                is_border, sweep_last;
   logic [3:0]          init_vld;
   logic                init_any;
   mwf_pkg::level_type  init_best;
   mwf_pkg::label_type  fl_lab;
   logic [2:0]          cap_km1;
   logic [mwf_pkg::DIM_BITS-1:0] csr_v;
   logic signed [31:0]  out_ext;

   assign n_cells  = width_ff * height_ff;
   assign n_last   = CMPW'(n_cells) - CMPW'(1);
   assign csr_acc  = csr_chan.valid && csr_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = (state_ff == mwf_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign req_acc  = req_chan.valid && req_chan.ready;
   assign load_acc = req_acc && (req_chan.opcode == mwf_pkg::OP_LOAD);
   assign read_acc = req_acc && (req_chan.opcode == mwf_pkg::OP_READ) &&
                     (phase_ff == mwf_pkg::PH_READING);
   assign ld_base  = (phase_ff == mwf_pkg::PH_READING) ? '0 : load_pos_ff;
   assign ld_p     = (CMPW'(ld_base) > n_last) ? '0 : ld_base;
   assign rd_p     = (CMPW'(read_pos_ff) > n_last) ? '0 : read_pos_ff;
   assign ld_last  = CMPW'(ld_p) == n_last;
   assign rd_last  = CMPW'(rd_p) == n_last;
   assign flood_go = load_acc && (req_chan.final_pixel || ld_last);

   assign nbr[0] = cur_p_ff - AW'(1);
   assign nbr[1] = cur_p_ff + AW'(1);
   assign nbr[2] = cur_p_ff - AW'(width_ff);
   assign nbr[3] = cur_p_ff + AW'(width_ff);
   assign fe_addr = (fe_k_ff == 3'd0) ? cur_p_ff : nbr[2'(fe_k_ff - 3'd1)];
   assign cap_km1 = cap_k_ff - 3'd1;

   assign is_border  = (row_ff == '0) || (col_ff == '0) ||
                       (row_ff == height_ff - 9'd1) || (col_ff == width_ff - 9'd1);
   assign sweep_last = (row_ff == height_ff - 9'd1) && (col_ff == width_ff - 9'd1);

   always_comb begin
      init_vld[0] = (nb_lab_ff[0] > 0) && (col_ff != 9'd1);
      init_vld[1] = (nb_lab_ff[1] > 0) && (col_ff != width_ff - 9'd2);
      init_vld[2] = (nb_lab_ff[2] > 0) && (row_ff != 9'd1);
      init_vld[3] = (nb_lab_ff[3] > 0) && (row_ff != height_ff - 9'd2);
      init_any  = 1'b0;
      init_best = '1;
      for (int k = 0; k < 4; k++) begin
         if (init_vld[k] && (!init_any || dist_ff[k] < init_best)) begin
            init_best = dist_ff[k];
            init_any  = 1'b1;
         end
      end
   end

   always_comb begin
      fl_lab = mwf_pkg::MARK_NONE;
      for (int k = 0; k < 4; k++) begin
         if (nb_lab_ff[k] > 0) begin
            if (fl_lab == mwf_pkg::MARK_NONE) fl_lab = nb_lab_ff[k];
            else if (nb_lab_ff[k] != fl_lab) fl_lab = mwf_pkg::MARK_WSHED;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mwf_pkg::ST_IDLE: begin
            if (flood_go) state_in = mwf_pkg::ST_SWEEP;
         end
         mwf_pkg::ST_SWEEP: begin
            state_in = is_border ? mwf_pkg::ST_NEXT : mwf_pkg::ST_FETCH;
         end
         mwf_pkg::ST_NEXT: begin
            state_in = sweep_last ? mwf_pkg::ST_SCAN : mwf_pkg::ST_SWEEP;
         end
         mwf_pkg::ST_FETCH: begin
            if (fe_k_ff == 3'd4) state_in = mwf_pkg::ST_WAIT;
         end
         mwf_pkg::ST_WAIT: begin
            state_in = init_mode_ff ? mwf_pkg::ST_INIT_EVAL : mwf_pkg::ST_FL_EVAL;
         end
         mwf_pkg::ST_INIT_EVAL: begin
            if (self_lab_ff <= 0 && init_any) state_in = mwf_pkg::ST_PUSH_A;
            else state_in = mwf_pkg::ST_NEXT;
         end
         mwf_pkg::ST_PUSH_A: begin
            state_in = mwf_pkg::ST_PUSH_B;
         end
         mwf_pkg::ST_PUSH_B: begin
            if (init_mode_ff) state_in = mwf_pkg::ST_NEXT;
            else if (nb_k_ff == 2'd3) state_in = mwf_pkg::ST_SCAN;
            else state_in = mwf_pkg::ST_FL_NB;
         end
         mwf_pkg::ST_SCAN: begin
            if (nonempty_ff[cur_level_ff]) state_in = mwf_pkg::ST_POP_A;
            else if (cur_level_ff == '1) state_in = mwf_pkg::ST_IDLE;
         end
         mwf_pkg::ST_POP_A: begin
            state_in = mwf_pkg::ST_POP_B;
         end
         mwf_pkg::ST_POP_B: begin
            state_in = (head_rd_ff == tail_rd_ff) ? mwf_pkg::ST_FETCH : mwf_pkg::ST_POP_C;
         end
         mwf_pkg::ST_POP_C: begin
            state_in = mwf_pkg::ST_FETCH;
         end
         mwf_pkg::ST_FL_EVAL: begin
            state_in = (fl_lab == mwf_pkg::MARK_WSHED) ? mwf_pkg::ST_SCAN : mwf_pkg::ST_FL_NB;
         end
         mwf_pkg::ST_FL_NB: begin
            if (nb_lab_ff[nb_k_ff] == mwf_pkg::MARK_NONE) state_in = mwf_pkg::ST_PUSH_A;
            else if (nb_k_ff == 2'd3) state_in = mwf_pkg::ST_SCAN;
         end
         default: state_in = mwf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      lab_re = 1'b0; lab_raddr = fe_addr;
      lab_we = 1'b0; lab_waddr = cur_p_ff; lab_wdata = mwf_pkg::MARK_NONE;
      col_re = 1'b0; col_raddr = fe_addr;
      col_we = 1'b0; col_waddr = ld_p;
      link_re = 1'b0; link_raddr = head_rd_ff;
      link_we = 1'b0; link_waddr = tail_rd_ff; link_wdata = tgt_ff;
      head_re = 1'b0; head_raddr = cur_level_ff;
      head_we = 1'b0; head_waddr = lev_ff; head_wdata = tgt_ff;
      tail_re = 1'b0; tail_raddr = lev_ff;
      tail_we = 1'b0; tail_waddr = lev_ff; tail_wdata = tgt_ff;
      unique case (state_ff)
         mwf_pkg::ST_IDLE: begin
            if (load_acc) begin
               col_we    = 1'b1;
               lab_we    = 1'b1;
               lab_waddr = ld_p;
               lab_wdata = mwf_pkg::label_type'({2'b00, req_chan.marker_label});
            end
            if (read_acc) begin
               lab_re    = 1'b1;
               lab_raddr = rd_p;
            end
         end
         mwf_pkg::ST_SWEEP: begin
            if (is_border) begin
               lab_we    = 1'b1;
               lab_wdata = mwf_pkg::MARK_WSHED;
            end
         end
         mwf_pkg::ST_FETCH: begin
            lab_re = 1'b1;
            col_re = 1'b1;
         end
         mwf_pkg::ST_INIT_EVAL: begin
            if (self_lab_ff <= 0 && !init_any) lab_we = 1'b1;
         end
         mwf_pkg::ST_PUSH_A: begin
            tail_re = 1'b1;
         end
         mwf_pkg::ST_PUSH_B: begin
            if (nonempty_ff[lev_ff]) link_we = 1'b1;
            else head_we = 1'b1;
            tail_we   = 1'b1;
            lab_we    = 1'b1;
            lab_waddr = tgt_ff;
            lab_wdata = mwf_pkg::MARK_QUEUED;
         end
         mwf_pkg::ST_POP_A: begin
            head_re    = 1'b1;
            tail_re    = 1'b1;
            tail_raddr = cur_level_ff;
         end
         mwf_pkg::ST_POP_B: begin
            if (head_rd_ff != tail_rd_ff) link_re = 1'b1;
         end
         mwf_pkg::ST_POP_C: begin
            head_we    = 1'b1;
            head_waddr = cur_level_ff;
            head_wdata = link_rd_ff;
         end
         mwf_pkg::ST_FL_EVAL: begin
            lab_we    = 1'b1;
            lab_wdata = fl_lab;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (col_we) colour_mem[col_waddr] <= {req_chan.pixel_red, req_chan.pixel_green,
                                            req_chan.pixel_blue};
      if (col_re) colour_rd_ff <= colour_mem[col_raddr];
   end

   always_ff @(posedge clock) begin
      if (lab_we) label_mem[lab_waddr] <= lab_wdata;
      if (lab_re) label_rd_ff <= label_mem[lab_raddr];
   end

   always_ff @(posedge clock) begin
      if (link_we) link_mem[link_waddr] <= link_wdata;
      if (link_re) link_rd_ff <= link_mem[link_raddr];
   end

   always_ff @(posedge clock) begin
      if (head_we) head_mem[head_waddr] <= head_wdata;
      if (head_re) head_rd_ff <= head_mem[head_raddr];
   end

   always_ff @(posedge clock) begin
      if (tail_we) tail_mem[tail_waddr] <= tail_wdata;
      if (tail_re) tail_rd_ff <= tail_mem[tail_raddr];
   end

   always_ff @(posedge clock) begin
      if (cap_vld_ff) begin
         if (cap_k_ff == 3'd0) begin
            self_col_ff <= colour_rd_ff;
            self_lab_ff <= label_rd_ff;
         end else begin
            nb_lab_ff[cap_km1[1:0]] <= label_rd_ff;
            dist_ff[cap_km1[1:0]]   <= mwf_pkg::colour_dist(self_col_ff, colour_rd_ff);
         end
      end
      if (state_ff == mwf_pkg::ST_INIT_EVAL) begin
         tgt_ff <= cur_p_ff;
         lev_ff <= init_best;
      end
      if (state_ff == mwf_pkg::ST_FL_NB) begin
         tgt_ff <= nbr[nb_k_ff];
         lev_ff <= dist_ff[nb_k_ff];
      end
      if (read_acc) rsp_final_ff <= rd_last;
   end

   assign csr_v = csr_chan.data;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mwf_pkg::ST_IDLE;
         phase_ff     <= mwf_pkg::PH_LOADING;
         width_ff     <= mwf_pkg::DIM_BITS'(RST_W);
         height_ff    <= mwf_pkg::DIM_BITS'(RST_H);
         load_pos_ff  <= '0;
         read_pos_ff  <= '0;
         nonempty_ff  <= '0;
         cur_level_ff <= '0;
         init_mode_ff <= 1'b0;
         cap_vld_ff   <= 1'b0;
         cap_k_ff     <= '0;
         fe_k_ff      <= '0;
         nb_k_ff      <= '0;
         cur_p_ff     <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cap_vld_ff <= (state_ff == mwf_pkg::ST_FETCH);
         cap_k_ff   <= fe_k_ff;

         if (csr_acc && (csr_chan.index == mwf_pkg::REG_IMAGE_WIDTH ||
                         csr_chan.index == mwf_pkg::REG_IMAGE_HEIGHT)) begin
            if (csr_chan.index == mwf_pkg::REG_IMAGE_WIDTH) begin
               if (csr_v < mwf_pkg::DIM_BITS'(mwf_pkg::MIN_DIM))
                  width_ff <= mwf_pkg::DIM_BITS'(mwf_pkg::MIN_DIM);
               else if (32'(csr_v) > MAX_WIDTH) width_ff <= mwf_pkg::DIM_BITS'(MAX_WIDTH);
               else width_ff <= csr_v;
            end else begin
               if (csr_v < mwf_pkg::DIM_BITS'(mwf_pkg::MIN_DIM))
                  height_ff <= mwf_pkg::DIM_BITS'(mwf_pkg::MIN_DIM);
               else if (32'(csr_v) > MAX_HEIGHT) height_ff <= mwf_pkg::DIM_BITS'(MAX_HEIGHT);
               else height_ff <= csr_v;
            end
            phase_ff    <= mwf_pkg::PH_LOADING;
            load_pos_ff <= '0;
            read_pos_ff <= '0;
         end

         if (read_acc) rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready) rsp_valid_ff <= 1'b0;

         if (load_acc) begin
            if (flood_go) begin
               phase_ff     <= mwf_pkg::PH_READING;
               load_pos_ff  <= '0;
               read_pos_ff  <= '0;
               nonempty_ff  <= '0;
               init_mode_ff <= 1'b1;
               cur_p_ff     <= '0;
               row_ff       <= '0;
               col_ff       <= '0;
            end else begin
               phase_ff    <= mwf_pkg::PH_LOADING;
               load_pos_ff <= ld_p + AW'(1);
            end
         end

         if (read_acc) begin
            if (rd_last) begin
               phase_ff    <= mwf_pkg::PH_LOADING;
               read_pos_ff <= '0;
               load_pos_ff <= '0;
            end else begin
               read_pos_ff <= rd_p + AW'(1);
            end
         end

         case (state_ff)
            mwf_pkg::ST_SWEEP: begin
               fe_k_ff <= '0;
            end
            mwf_pkg::ST_NEXT: begin
               if (sweep_last) begin
                  cur_level_ff <= '0;
                  init_mode_ff <= 1'b0;
               end else begin
                  cur_p_ff <= cur_p_ff + AW'(1);
                  if (col_ff == width_ff - 9'd1) begin
                     col_ff <= '0;
                     row_ff <= row_ff + 9'd1;
                  end else begin
                     col_ff <= col_ff + 9'd1;
                  end
               end
            end
            mwf_pkg::ST_FETCH: begin
               fe_k_ff <= fe_k_ff + 3'd1;
            end
            mwf_pkg::ST_PUSH_B: begin
               nonempty_ff[lev_ff] <= 1'b1;
               if (!init_mode_ff) begin
                  if (lev_ff < cur_level_ff) cur_level_ff <= lev_ff;
                  nb_k_ff <= nb_k_ff + 2'd1;
               end
            end
            mwf_pkg::ST_SCAN: begin
               if (!nonempty_ff[cur_level_ff] && cur_level_ff != '1)
                  cur_level_ff <= cur_level_ff + 8'd1;
            end
            mwf_pkg::ST_POP_B: begin
               cur_p_ff <= head_rd_ff;
               fe_k_ff  <= '0;
               if (head_rd_ff == tail_rd_ff) nonempty_ff[cur_level_ff] <= 1'b0;
            end
            mwf_pkg::ST_FL_EVAL: begin
               nb_k_ff <= '0;
            end
            mwf_pkg::ST_FL_NB: begin
               if (nb_lab_ff[nb_k_ff] != mwf_pkg::MARK_NONE) nb_k_ff <= nb_k_ff + 2'd1;
            end
            default: begin
            end
         endcase
      end
   end

   assign out_ext = 32'(label_rd_ff);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.region_label = out_ext[LABEL_BITS-1:0];
   assign rsp_chan.final_label  = rsp_final_ff;

`ifndef ASSERT_OFF
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(req_chan.valid && req_chan.ready &&
                                       req_chan.opcode == mwf_pkg::OP_READ))
      else $error("Response raised without an accepted read request.");
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff != mwf_pkg::ST_IDLE |-> !req_chan.ready)
      else $error("Request taken while flooding.");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == mwf_pkg::ST_POP_A |-> nonempty_ff[cur_level_ff])
      else $error("Pop from an empty level.");
   a_csr_loading: assert property (@(posedge clock) disable iff (reset)
      (csr_acc && csr_chan.index == mwf_pkg::REG_IMAGE_WIDTH && !req_chan.valid)
      |=> phase_ff == mwf_pkg::PH_LOADING)
      else $error("Register write did not return to loading.");
`endif

endmodule
